>>> src/mips_ie_pkg.sv
package mips_ie_pkg;

  localparam int unsigned RegCount = 32;
  localparam logic [31:0] StartReset = 32'h0040_0000;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_LUI     = 6'h0F;

  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_MFHI  = 6'h10;
  localparam logic [5:0] FN_MTHI  = 6'h11;
  localparam logic [5:0] FN_MFLO  = 6'h12;
  localparam logic [5:0] FN_MTLO  = 6'h13;
  localparam logic [5:0] FN_MULT  = 6'h18;
  localparam logic [5:0] FN_MULTU = 6'h19;
  localparam logic [5:0] FN_DIV   = 6'h1A;
  localparam logic [5:0] FN_DIVU  = 6'h1B;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;

  localparam logic [1:0] MD_MULT  = 2'd0;
  localparam logic [1:0] MD_MULTU = 2'd1;
  localparam logic [1:0] MD_DIV   = 2'd2;
  localparam logic [1:0] MD_DIVU  = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } md_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

endpackage

>>> src/mips_ie_muldiv.sv
module mips_ie_muldiv
  import mips_ie_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  md_req_t     req,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output md_stat_t    stat,
  output logic [31:0] hi,
  output logic [31:0] lo
);

  // shift-add multiply and restoring divide on magnitudes, one bit a cycle
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic        is_div;
  logic        neg_q;
  logic        neg_r;
  logic        dz;
  logic [31:0] dvsr;
  logic [31:0] orig_a;
  logic [63:0] acc;
  logic [31:0] ma;
  logic [31:0] mb;
  logic        sgn;
  logic [32:0] sum;
  logic [32:0] diff;
  logic [63:0] prod_n;
  logic [31:0] q_n;
  logic [31:0] r_n;

  assign sgn = (req.op == MD_MULT) || (req.op == MD_DIV);
  assign ma  = (sgn && a[31]) ? (~a + 32'd1) : a;
  assign mb  = (sgn && b[31]) ? (~b + 32'd1) : b;
  assign sum  = {1'b0, acc[63:32]} + (acc[0] ? {1'b0, dvsr} : 33'd0);
  assign diff = {acc[63:31]} - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      is_div <= req.op[1];
      dvsr   <= mb;
      orig_a <= a;
      dz     <= (b == 32'd0);
      neg_q  <= sgn && (a[31] ^ b[31]);
      neg_r  <= sgn && a[31];
      acc    <= {32'd0, ma};
    end else if (busy) begin
      if (!is_div) begin
        acc <= {sum, acc[31:1]};
      end else if (!diff[32]) begin
        acc <= {diff[31:0], acc[30:0], 1'b1};
      end else begin
        acc <= {acc[62:0], 1'b0};
      end
    end
  end

  assign prod_n = neg_q ? (64'd0 - acc) : acc;
  assign q_n    = neg_q ? (~acc[31:0] + 32'd1) : acc[31:0];
  assign r_n    = neg_r ? (~acc[63:32] + 32'd1) : acc[63:32];

  always_comb begin
    if (!is_div) begin
      hi = prod_n[63:32];
      lo = prod_n[31:0];
    end else if (dz) begin
      hi = orig_a;
      lo = 32'hFFFF_FFFF;
    end else begin
      hi = r_n;
      lo = q_n;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("muldiv done while busy");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != 6'd0)
    else $error("muldiv busy with zero count");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (req.start && !busy) |=> busy)
    else $error("muldiv start not taken");

endmodule

>>> src/mips32_integer_execute.sv
// channel  dir  signals                  content
// s_axis   in   tvalid tready tdata[31:0] instruction_word
// m_axis   out  tvalid tready tdata[135:0] next_pc, written flag, index, value, hi, lo, unknown
// apb      in   psel penable pwrite paddr pwdata prdata pready; start_address at 0
//
// an instruction passes through register file read (registered memory), execute and
// write back, and result load; multiply and divide add a wait on the one-bit-a-cycle unit
// one instruction in flight at a time; the result register lets the next read start
// while the result waits for tready
// rst loads pc with the start_address reset value and clears hi, lo; the 32-entry file
// is cleared by a sweep over every entry after reset, during which s_tready stays low
module mips32_integer_execute
  import mips_ie_pkg::*;
#(
  parameter int unsigned REG_COUNT = RegCount
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // instruction_word
  output logic         m_tvalid,
  input  logic         m_tready,
  // next_pc[31:0] reg_written[32] dest_index[37:33] dest_value[69:38]
  // hi_value[101:70] lo_value[133:102] unknown_instr[134] zero pad[135]
  output logic [135:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IW = $clog2(REG_COUNT);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_EXE  = 3'd2;
  localparam logic [2:0] ST_MD   = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [31:0] start_address;
  logic [2:0]  state;
  logic [IW:0] clr_cnt;
  logic [31:0] pc;
  logic [31:0] hi_r;
  logic [31:0] lo_r;
  logic [31:0] ins;
  logic [31:0] rf [REG_COUNT];
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic        we;
  logic [IW-1:0] wa;
  logic [31:0] wd;

  // result under build and result register
  logic [135:0] res;
  logic         res_valid;

  // decode
  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [31:0] a;
  logic [31:0] b;
  logic [31:0] imm_s;
  logic [31:0] pc4;
  logic [31:0] btarget;
  logic [31:0] npc;
  logic [31:0] hi_n;
  logic [31:0] lo_n;
  logic [31:0] dv;
  logic [4:0]  di;
  logic        wr;
  logic        unk;
  logic        md;
  logic [1:0]  md_op;
  logic [31:0] sra_v;

  md_req_t     md_req;
  md_stat_t    md_stat;
  logic [31:0] md_hi;
  logic [31:0] md_lo;

  logic accept_in;
  logic accept_out;

  assign pready = 1'b1;
  assign prdata = start_address;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_address <= StartReset;
    end else if (psel && penable && pwrite && !paddr) begin
      start_address <= pwdata;
    end
  end

  assign accept_in  = s_tvalid && s_tready;
  assign accept_out = m_tvalid && m_tready;
  assign s_tready   = (state == ST_IDLE);
  assign m_tvalid   = res_valid;

  // register file: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (we) begin
      rf[wa] <= wd;
    end
    rd_a <= rf[s_tdata[21 +: IW]];
    rd_b <= rf[s_tdata[16 +: IW]];
  end

  assign op = ins[31:26];
  assign rt = ins[20:16];
  assign rd = ins[15:11];
  assign sa = ins[10:6];
  assign fn = ins[5:0];
  // r0 holds zero after the clear and is never written, so no bypass needed
  assign a  = rd_a;
  assign b  = rd_b;
  assign imm_s   = {{16{ins[15]}}, ins[15:0]};
  assign pc4     = pc + 32'd4;
  assign btarget = pc4 + {imm_s[29:0], 2'b00};
  assign sra_v   = $signed(b) >>> sa;

  always_comb begin
    npc   = pc4;
    hi_n  = hi_r;
    lo_n  = lo_r;
    dv    = 32'd0;
    di    = 5'd0;
    wr    = 1'b0;
    unk   = 1'b0;
    md    = 1'b0;
    md_op = MD_MULT;
    case (op)
      OP_SPECIAL: begin
        wr = 1'b1;
        di = rd;
        case (fn)
          FN_ADD, FN_ADDU: dv = a + b;
          FN_SUB, FN_SUBU: dv = a - b;
          FN_AND:  dv = a & b;
          FN_OR:   dv = a | b;
          FN_XOR:  dv = a ^ b;
          FN_NOR:  dv = ~(a | b);
          FN_SLT:  dv = {31'd0, $signed(a) < $signed(b)};
          FN_SLL:  dv = b << sa;
          FN_SRL:  dv = b >> sa;
          FN_SRA:  dv = sra_v;
          FN_MFHI: dv = hi_r;
          FN_MFLO: dv = lo_r;
          FN_MTHI: begin wr = 1'b0; hi_n = a; end
          FN_MTLO: begin wr = 1'b0; lo_n = a; end
          FN_MULT:  begin wr = 1'b0; md = 1'b1; md_op = MD_MULT; end
          FN_MULTU: begin wr = 1'b0; md = 1'b1; md_op = MD_MULTU; end
          FN_DIV:   begin wr = 1'b0; md = 1'b1; md_op = MD_DIV; end
          FN_DIVU:  begin wr = 1'b0; md = 1'b1; md_op = MD_DIVU; end
          default: begin wr = 1'b0; unk = 1'b1; end
        endcase
      end
      OP_REGIMM: begin
        if (rt == 5'd0) begin
          if (a[31]) npc = btarget;
        end else if (rt == 5'd1) begin
          if (!a[31]) npc = btarget;
        end else begin
          unk = 1'b1;
        end
      end
      OP_ADDI, OP_ADDIU: begin wr = 1'b1; di = rt; dv = a + imm_s; end
      OP_SLTI: begin wr = 1'b1; di = rt; dv = {31'd0, $signed(a) < $signed(imm_s)}; end
      OP_ANDI: begin wr = 1'b1; di = rt; dv = {16'd0, a[15:0] & ins[15:0]}; end
      OP_LUI:  begin wr = 1'b1; di = rt; dv = {ins[15:0], 16'd0}; end
      OP_BEQ:  if (a == b) npc = btarget;
      OP_BNE:  if (a != b) npc = btarget;
      OP_BLEZ: if (a[31] || a == 32'd0) npc = btarget;
      OP_BGTZ: if (!a[31] && a != 32'd0) npc = btarget;
      OP_J:    npc = {pc4[31:28], ins[25:0], 2'b00};
      default: unk = 1'b1;
    endcase
    if (di == 5'd0) begin
      wr = 1'b0;
    end
    if (!wr) begin
      di = 5'd0;
      dv = 32'd0;
    end
  end

  assign md_req.start = (state == ST_EXE) && md;
  assign md_req.op    = md_op;

  mips_ie_muldiv u_md (
    .clk  (clk),
    .rst  (rst),
    .req  (md_req),
    .a    (a),
    .b    (b),
    .stat (md_stat),
    .hi   (md_hi),
    .lo   (md_lo)
  );

  // write port: clearing sweep or execute write back
  always_comb begin
    if (state == ST_CLR) begin
      we = 1'b1;
      wa = clr_cnt[IW-1:0];
      wd = 32'd0;
    end else begin
      we = (state == ST_EXE) && wr;
      wa = di[IW-1:0];
      wd = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      clr_cnt   <= '0;
      pc        <= StartReset;
      hi_r      <= 32'd0;
      lo_r      <= 32'd0;
      res_valid <= 1'b0;
    end else begin
      // loaded from the out state when free or draining, else held until the transfer
      res_valid <= (state == ST_OUT && (!res_valid || m_tready)) ||
                   (res_valid && !m_tready);
      case (state)
        ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (IW+1)'(REG_COUNT - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept_in) begin
            state <= ST_EXE;
          end
        end
        ST_EXE: begin
          pc <= npc;
          if (md) begin
            state <= ST_MD;
          end else begin
            hi_r  <= hi_n;
            lo_r  <= lo_n;
            state <= ST_OUT;
          end
        end
        ST_MD: begin
          if (md_stat.done) begin
            hi_r  <= md_hi;
            lo_r  <= md_lo;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // result register free or being drained this cycle
          if (!res_valid || m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      ins <= s_tdata;
    end
    if (state == ST_EXE) begin
      res[31:0]   <= npc;
      res[32]     <= wr;
      res[37:33]  <= di;
      res[69:38]  <= dv;
      res[134]    <= unk;
      res[135]    <= 1'b0;
    end
    if (state == ST_OUT) begin
      res[101:70]  <= hi_r;
      res[133:102] <= lo_r;
    end
    if (state == ST_OUT && (!res_valid || m_tready)) begin
      m_tdata <= {res[135:134], lo_r, hi_r, res[69:0]};
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == ST_IDLE)
    else $error("ready outside idle");
  a_clear_closed: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLR |-> !accept_in)
    else $error("item taken during clear");
  a_md_wait: assert property (@(posedge clk) disable iff (rst)
    md_stat.busy |-> state == ST_MD)
    else $error("muldiv busy outside wait");

endmodule
